/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks prop on every rising clock edge outside reset.
`define CSD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSD_ASSERT(label, clk, rst_n, prop, msg)

`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/csd_pkg.sv */
`default_nettype none

package csd_pkg;

    // Default number of descriptor slots.
    localparam int TABLE_DEPTH_DEF = 16;

    localparam int FRAME_BYTES = 8;
    localparam int WORD_BITS   = 64;

    // Values of the action field.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // One input item: a descriptor write or a received frame.
    typedef struct packed {
        logic               action;
        logic [3:0]         entry_index;
        logic               entry_enable;
        logic [28:0]        can_id;
        logic               msb_first;
        logic [5:0]         start_pos;
        logic [6:0]         bit_length;
        logic               is_signed;
        logic signed [31:0] gain;
        logic signed [31:0] offset;
        logic [3:0]         frame_len;
        logic [63:0]        frame_data;
    } req_item_t;

    // One result item per matching descriptor.
    typedef struct packed {
        logic [3:0]         sensor_index;
        logic signed [63:0] value;
        logic               last;
    } rsp_item_t;

    // Descriptor fields kept in the table, apart from the enable bit, gain and offset.
    typedef struct packed {
        logic [28:0] can_id;
        logic        msb_first;
        logic [5:0]  start_pos;
        logic [6:0]  bit_length;
        logic        is_signed;
    } sig_desc_t;

    // Command to the scaling unit.
    typedef struct packed {
        logic               start;
        logic [63:0]        raw;
        logic signed [31:0] gain;
        logic signed [31:0] offset;
    } scl_cmd_t;

    // Status of the scaling unit.
    typedef struct packed {
        logic busy;
        logic done;
    } scl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/csd_stream_if.sv */
`default_nettype none

// Valid/ready channel carrying one item per handshake.
interface csd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/csd_table.sv */
`default_nettype none

// Descriptor store. Enable bits live in flip-flops cleared by reset; the
// remaining fields are held in memories with a registered read port.
module csd_table #(
    parameter int TABLE_DEPTH = csd_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_index,
    input  wire logic               wr_enable,
    input  wire csd_pkg::sig_desc_t wr_desc,
    input  wire logic signed [31:0] wr_gain,
    input  wire logic signed [31:0] wr_offset,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_index,
    output logic                    rd_enable,
    output csd_pkg::sig_desc_t      rd_desc,
    output logic signed [31:0]      rd_gain,
    output logic signed [31:0]      rd_offset
);
    import csd_pkg::*;

    logic [TABLE_DEPTH-1:0] enable_reg;
    logic                   rd_enable_reg;
    sig_desc_t              desc_mem [TABLE_DEPTH];
    logic signed [31:0]     gain_mem [TABLE_DEPTH];
    logic signed [31:0]     offset_mem [TABLE_DEPTH];
    sig_desc_t              rd_desc_reg;
    logic signed [31:0]     rd_gain_reg;
    logic signed [31:0]     rd_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            rd_enable_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                enable_reg[wr_index] <= wr_enable;
            end
            if (rd_en)
            begin
                rd_enable_reg <= enable_reg[rd_index];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_index]   <= wr_desc;
            gain_mem[wr_index]   <= wr_gain;
            offset_mem[wr_index] <= wr_offset;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_desc_reg   <= desc_mem[rd_index];
            rd_gain_reg   <= gain_mem[rd_index];
            rd_offset_reg <= offset_mem[rd_index];
        end
    end

    assign rd_enable = rd_enable_reg;
    assign rd_desc   = rd_desc_reg;
    assign rd_gain   = rd_gain_reg;
    assign rd_offset = rd_offset_reg;

endmodule

`default_nettype wire

/* hw/rtl/csd_extract.sv */
`default_nettype none

// Pulls the raw signal out of the frame payload for one descriptor and
// applies sign extension.
module csd_extract (
    input  wire csd_pkg::sig_desc_t desc,
    input  wire logic [3:0]         frame_len,
    input  wire logic [63:0]        frame_data,
    output logic [63:0]             raw
);
    import csd_pkg::*;

    logic [3:0]  nbytes;
    logic        be_ok;
    logic [63:0] be_shift;
    logic [63:0] be_raw;
    logic [63:0] len_mask;
    logic [63:0] field_mask;
    logic [63:0] le_raw;
    logic [63:0] raw_u;
    logic        sext;
    logic        sign_bit;

    always_comb
    begin
        // Whole bytes for big-endian signals; a zero count means one byte.
        nbytes = (desc.bit_length[6:3] == 4'd0) ? 4'd1 : desc.bit_length[6:3];
        be_ok  = (({1'b0, desc.start_pos} + {3'b000, nbytes}) <= {3'b000, frame_len})
                 && (nbytes == 4'd1 || nbytes == 4'd2 || nbytes == 4'd4);
        be_shift = frame_data >> {desc.start_pos[2:0], 3'b000};
        case (nbytes)
            4'd1:    be_raw = {56'd0, be_shift[7:0]};
            4'd2:    be_raw = {48'd0, be_shift[7:0], be_shift[15:8]};
            4'd4:    be_raw = {32'd0, be_shift[7:0], be_shift[15:8],
                               be_shift[23:16], be_shift[31:24]};
            default: be_raw = '0;
        endcase

        // Bytes beyond the frame length read as zero.
        len_mask = (frame_len >= 4'(FRAME_BYTES)) ? '1
                 : ((64'd1 << {frame_len, 3'b000}) - 64'd1);
        field_mask = (desc.bit_length >= 7'(WORD_BITS)) ? '1
                   : ((64'd1 << desc.bit_length) - 64'd1);
        le_raw = ((frame_data & len_mask) >> desc.start_pos) & field_mask;

        if (desc.msb_first)
        begin
            raw_u = be_ok ? be_raw : '0;
        end
        else
        begin
            raw_u = le_raw;
        end

        sext     = desc.is_signed && (desc.bit_length != 7'd0)
                   && (desc.bit_length < 7'(WORD_BITS));
        sign_bit = raw_u[desc.bit_length[5:0] - 6'd1];
        if (sext)
        begin
            raw = (raw_u & field_mask) | (sign_bit ? ~field_mask : '0);
        end
        else
        begin
            raw = raw_u;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/csd_scaler.sv */
`default_nettype none

// Computes raw * gain + offset in Q16.16 with 64-bit saturation. A single
// 33 by 33 bit signed multiplier is used twice, once per half of the raw
// value, and the partial products are combined in one wide add.
module csd_scaler (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csd_pkg::scl_cmd_t cmd,
    output csd_pkg::scl_stat_t     stat,
    output logic signed [63:0]     result
);
    import csd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL_LO = 5'b00010,
        S_MUL_HI = 5'b00100,
        S_ADD    = 5'b01000,
        S_SAT    = 5'b10000
    } scl_state_t;

    scl_state_t         state_reg;
    scl_state_t         state_next;
    logic [63:0]        raw_reg;
    logic signed [31:0] gain_reg;
    logic signed [31:0] off_reg;
    logic signed [63:0] plo_reg;
    logic signed [63:0] phi_reg;
    logic signed [95:0] sum_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [95:0] sum_next;
    logic               fits;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (cmd.start) state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_ADD;
            S_ADD:    state_next = S_SAT;
            S_SAT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The low half is unsigned, the high half carries the sign.
    assign mul_a = (state_reg == S_MUL_HI) ? {raw_reg[63], raw_reg[63:32]}
                                           : {1'b0, raw_reg[31:0]};
    assign mul_b = {gain_reg[31], gain_reg};
    assign mul_p = mul_a * mul_b;

    assign sum_next = {phi_reg, 32'd0}
                    + {{32{plo_reg[63]}}, plo_reg}
                    + {{64{off_reg[31]}}, off_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd.start)
        begin
            raw_reg  <= cmd.raw;
            gain_reg <= cmd.gain;
            off_reg  <= cmd.offset;
        end
        if (state_reg == S_MUL_LO)
        begin
            plo_reg <= mul_p[63:0];
        end
        if (state_reg == S_MUL_HI)
        begin
            phi_reg <= mul_p[63:0];
        end
        if (state_reg == S_ADD)
        begin
            sum_reg <= sum_next;
        end
    end

    // The sum fits when its upper bits all repeat the sign of bit 63.
    assign fits   = (&sum_reg[95:63]) || !(|sum_reg[95:63]);
    assign result = fits ? sum_reg[63:0]
                  : (sum_reg[95] ? 64'sh8000_0000_0000_0000
                                 : 64'sh7FFF_FFFF_FFFF_FFFF);

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_SAT);

endmodule

`default_nettype wire

/* hw/rtl/can_signal_table_decoder.sv */
`default_nettype none
`include "assert_macros.svh"

// CAN signal table decoder. The block keeps TABLE_DEPTH signal descriptors
// and turns each received frame into one result item for every enabled
// descriptor whose identifier equals the frame identifier, in ascending slot
// order, with the last result of the frame marked. A write item (action 0)
// loads one descriptor and produces no result; slots at or beyond
// TABLE_DEPTH are ignored. A frame item (action 1) walks the table one entry
// per cycle, while no match is being scaled and no stall holds it, through
// the registered read port of the descriptor store. Each match is scaled in
// the shared scaling unit, which runs its single 33 by 33 bit multiplier
// over both halves of the raw value, sums the partial products with the
// offset and saturates. New items are refused until the walk of the current
// frame is finished and its last result has gone to the output register; a
// finished result sits in an output register, so the block goes on working
// while the sink stalls, and it waits only when a further result would need
// that register. Values are signed Q16.16 in gain and offset and signed
// Q48.16 out, saturated to 64 bits.
module can_signal_table_decoder #(
    parameter int TABLE_DEPTH = csd_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    csd_stream_if.sink   req,
    csd_stream_if.source rsp
);
    import csd_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W = IDX_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_FLUSH = 4'b1000
    } seq_state_t;

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic               chk_valid_reg;
    logic               chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [IDX_W-1:0]   chk_idx_next;
    logic [28:0]        id_reg;
    logic [3:0]         len_reg;
    logic [63:0]        data_reg;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [3:0]         pend_idx_reg;
    logic [3:0]         pend_idx_next;
    logic signed [63:0] pend_value_reg;
    logic signed [63:0] pend_value_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_item_t          out_item_reg;

    logic               req_fire;
    logic               rsp_fire;
    logic               frame_load;
    logic               wr_en;
    logic               rd_en;
    logic               out_free;
    logic               match;
    logic               stall;
    logic               out_load;
    logic               out_last;
    logic               scl_start;

    logic               tbl_enable;
    sig_desc_t          tbl_desc;
    logic signed [31:0] tbl_gain;
    logic signed [31:0] tbl_offset;
    sig_desc_t          wr_desc;
    logic [63:0]        raw;
    scl_cmd_t           scl_cmd;
    scl_stat_t          scl_stat;
    logic signed [63:0] scl_result;

    assign req_fire = req.valid && req.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Descriptor writes are taken only while idle, so they never meet a walk.
    assign wr_en = req_fire && (req.payload.action == ACT_WRITE)
                   && ({28'd0, req.payload.entry_index} < 32'(TABLE_DEPTH));
    assign frame_load = req_fire && (req.payload.action == ACT_DECODE);

    assign wr_desc.can_id     = req.payload.can_id;
    assign wr_desc.msb_first  = req.payload.msb_first;
    assign wr_desc.start_pos  = req.payload.start_pos;
    assign wr_desc.bit_length = req.payload.bit_length;
    assign wr_desc.is_signed  = req.payload.is_signed;

    csd_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (IDX_W'(req.payload.entry_index)),
        .wr_enable (req.payload.entry_enable),
        .wr_desc   (wr_desc),
        .wr_gain   (req.payload.gain),
        .wr_offset (req.payload.offset),
        .rd_en     (rd_en),
        .rd_index  (addr_reg[IDX_W-1:0]),
        .rd_enable (tbl_enable),
        .rd_desc   (tbl_desc),
        .rd_gain   (tbl_gain),
        .rd_offset (tbl_offset)
    );

    csd_extract u_extract (
        .desc       (tbl_desc),
        .frame_len  (len_reg),
        .frame_data (data_reg),
        .raw        (raw)
    );

    csd_scaler u_scaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (scl_cmd),
        .stat   (scl_stat),
        .result (scl_result)
    );

    // The entry on the table read port is checked in the same cycle as the
    // next read is issued.
    assign match = chk_valid_reg && tbl_enable && (tbl_desc.can_id == id_reg);

    // A new match needs the pending result moved out first.
    assign stall = match && pend_valid_reg && !out_free;

    assign scl_cmd.start  = scl_start;
    assign scl_cmd.raw    = raw;
    assign scl_cmd.gain   = tbl_gain;
    assign scl_cmd.offset = tbl_offset;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_value_next = pend_value_reg;
        rd_en           = 1'b0;
        scl_start       = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_load)
                begin
                    addr_next      = '0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (addr_reg < ADDR_W'(TABLE_DEPTH))
                    begin
                        rd_en          = 1'b1;
                        chk_idx_next   = addr_reg[IDX_W-1:0];
                        addr_next      = addr_reg + ADDR_W'(1);
                        chk_valid_next = 1'b1;
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                    end

                    if (match)
                    begin
                        scl_start       = 1'b1;
                        out_load        = pend_valid_reg;
                        pend_valid_next = 1'b0;
                        pend_idx_next   = 4'(chk_idx_reg);
                        state_next      = ST_SCALE;
                    end
                    else if (!chk_valid_reg && (addr_reg == ADDR_W'(TABLE_DEPTH)))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_SCALE:
            begin
                if (scl_stat.done)
                begin
                    pend_value_next = scl_result;
                    pend_valid_next = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                // The result still pending is the last one of the frame.
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pend_value_reg <= pend_value_next;
        if (frame_load)
        begin
            id_reg   <= req.payload.can_id;
            len_reg  <= (req.payload.frame_len > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                                 : req.payload.frame_len;
            data_reg <= req.payload.frame_data;
        end
        if (out_load)
        begin
            out_item_reg.sensor_index <= pend_idx_reg;
            out_item_reg.value        <= pend_value_reg;
            out_item_reg.last         <= out_last;
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    `CSD_ASSERT(a_scl_start_idle, clk, rst_n, scl_cmd.start |-> !scl_stat.busy, "scaler started while busy")
    `CSD_ASSERT(a_scl_done_scale, clk, rst_n, scl_stat.done |-> (state_reg == ST_SCALE), "scaler result outside the scale step")
    `CSD_ASSERT(a_idle_no_pend, clk, rst_n, (state_reg == ST_IDLE) |-> !pend_valid_reg, "result left pending after a frame")
    `CSD_ASSERT(a_addr_bound, clk, rst_n, addr_reg <= ADDR_W'(TABLE_DEPTH), "table walk ran past the last slot")
    `CSD_ASSERT_NEXT(a_frame_starts, clk, rst_n, frame_load, (state_reg == ST_SCAN) && !chk_valid_reg, "frame accepted without starting a walk")

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;

    import csd_pkg::*;

    // Longest run of cycles with no item moving on either channel before the
    // run is declared hung. It leaves a wide margin over the slowest frame (all
    // sixteen slots matching), with the sink's random stalls added.
    localparam int STALL_LIMIT = 2000;

    // Cycles allowed after the last expected result, so that a spurious extra
    // result from the final frame still has time to show up.
    localparam int DRAIN_CYCLES = 100;

    localparam logic [31:0] Q16_ONE = 32'h0001_0000;
    localparam logic [31:0] Q16_MIN = 32'h8000_0000;
    localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q16_NEG = 32'hFFFF_FFFF;

    // Scoreboard: keeps its own copy of the descriptor table, works out the
    // results that each accepted frame must produce, and checks the results
    // that the block hands out against them, oldest first.
    class frame_decode_scoreboard;

        typedef struct packed {
            logic        en;
            sig_desc_t   d;
            logic [31:0] gain;
            logic [31:0] offset;
        } slot_t;

        slot_t      slots[TABLE_DEPTH_DEF];
        rsp_item_t  expected_results[$];
        int         errors = 0;
        int         writes = 0;
        int         frames = 0;
        int         results = 0;
        int         saturations = 0;
        int         busiest = 0;

        function new();
            for (int i = 0; i < TABLE_DEPTH_DEF; i++)
                slots[i] = '0;
        endfunction

        // Extracts the raw field for one descriptor, sign-extends it where
        // asked, then scales it in Q16.16 and clamps to the signed 64-bit range.
        function logic [63:0] predict_signal_value(slot_t s, int unsigned len,
                                                   logic [63:0] data);
            logic [63:0]         raw;
            logic [63:0]         window;
            logic [63:0]         mask;
            int unsigned         nbytes;
            int unsigned         blen;
            logic signed [127:0] raw_w;
            logic signed [127:0] gain_w;
            logic signed [127:0] off_w;
            logic signed [127:0] wide;

            raw  = '0;
            blen = s.d.bit_length;
            if (s.d.msb_first)
            begin
                nbytes = (blen / 8 == 0) ? 1 : blen / 8;
                if (int'(s.d.start_pos) + nbytes <= len
                    && (nbytes == 1 || nbytes == 2 || nbytes == 4))
                begin
                    for (int k = 0; k < nbytes; k++)
                        raw = (raw << 8) | 64'(data[(int'(s.d.start_pos) + k) * 8 +: 8]);
                end
            end
            else
            begin
                window = (len >= 8) ? data : data & ((64'd1 << (len * 8)) - 64'd1);
                mask   = (blen >= 64) ? '1 : (64'd1 << blen) - 64'd1;
                raw    = (window >> s.d.start_pos) & mask;
            end

            if (s.d.is_signed && blen > 0 && blen < 64)
            begin
                mask = (64'd1 << blen) - 64'd1;
                raw  = raw & mask;
                if (raw[blen - 1])
                    raw = raw | ~mask;
            end

            raw_w  = $signed(raw);
            gain_w = $signed(s.gain);
            off_w  = $signed(s.offset);
            wide   = raw_w * gain_w + off_w;
            if (wide[127:63] == '0 || wide[127:63] == '1)
                return wide[63:0];
            saturations++;
            return wide[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        endfunction

        function void note_input(req_item_t it);
            int unsigned len;
            int          total;
            int          hits;
            rsp_item_t   want;

            if (it.action == ACT_WRITE)
            begin
                slots[it.entry_index] = '{en: it.entry_enable,
                                          d: '{can_id: it.can_id,
                                               msb_first: it.msb_first,
                                               start_pos: it.start_pos,
                                               bit_length: it.bit_length,
                                               is_signed: it.is_signed},
                                          gain: it.gain,
                                          offset: it.offset};
                writes++;
            end
            else
            begin
                frames++;
                len   = (it.frame_len > 8) ? 8 : it.frame_len;
                total = 0;
                for (int i = 0; i < TABLE_DEPTH_DEF; i++)
                    if (slots[i].en && slots[i].d.can_id == it.can_id)
                        total++;
                hits = 0;
                for (int i = 0; i < TABLE_DEPTH_DEF; i++)
                begin
                    if (slots[i].en && slots[i].d.can_id == it.can_id)
                    begin
                        hits++;
                        want.sensor_index = 4'(i);
                        want.value        = predict_signal_value(slots[i], len,
                                                                 it.frame_data);
                        want.last         = (hits == total);
                        expected_results.push_back(want);
                    end
                end
                if (total > busiest)
                    busiest = total;
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;

            if (expected_results.size() == 0)
            begin
                $error("unexpected result: sensor_index %0d value %0d last %0b",
                       got.sensor_index, $signed(got.value), got.last);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results++;
                if (got.sensor_index !== want.sensor_index)
                begin
                    $error("sensor_index: expected %0d, actual %0d",
                           want.sensor_index, got.sensor_index);
                    errors++;
                end
                if (got.value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d",
                           $signed(want.value), $signed(got.value));
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, got.last);
                    errors++;
                end
            end
        endfunction

    endclass

    logic clk = 1'b0;
    logic rst_n;

    // While this is set neither side inserts idle cycles, so back-to-back
    // items and an always-ready sink are exercised as well.
    bit steady = 1'b0;

    int items_sent = 0;
    int quiet_cycles = 0;

    frame_decode_scoreboard scoreboard = new();

    csd_stream_if #(.payload_t(req_item_t)) req_if ();
    csd_stream_if #(.payload_t(rsp_item_t)) rsp_if ();

    can_signal_table_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Each side idles at random with a chance of 37 in a hundred, except in the
    // steady stretch.
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 37);
    endfunction

    // Fills every field with random bits, so that the fields which the chosen
    // action does not use still toggle.
    function automatic req_item_t random_bits();
        logic [191:0] pool;

        pool = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return pool[$bits(req_item_t) - 1:0];
    endfunction

    function automatic req_item_t make_write(logic [3:0] idx, logic en, logic [28:0] id,
                                             logic be, logic [5:0] pos, logic [6:0] blen,
                                             logic sgn, logic [31:0] gain,
                                             logic [31:0] offset);
        req_item_t it;

        it              = random_bits();
        it.action       = ACT_WRITE;
        it.entry_index  = idx;
        it.entry_enable = en;
        it.can_id       = id;
        it.msb_first    = be;
        it.start_pos    = pos;
        it.bit_length   = blen;
        it.is_signed    = sgn;
        it.gain         = gain;
        it.offset       = offset;
        return it;
    endfunction

    function automatic req_item_t make_frame(logic [28:0] id, logic [3:0] len,
                                             logic [63:0] data);
        req_item_t it;

        it            = random_bits();
        it.action     = ACT_DECODE;
        it.can_id     = id;
        it.frame_len  = len;
        it.frame_data = data;
        return it;
    endfunction

    // Gain or offset: the extremes, full-range noise, or modest Q16.16 values
    // of either sign, which keep most results away from saturation.
    function automatic logic [31:0] pick_q16();
        int unsigned mag;

        case ($urandom_range(4))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: return Q16_MIN;
                    1: return Q16_MAX;
                    2: return Q16_NEG;
                    3: return 32'h0;
                    default: return Q16_ONE;
                endcase
            end
            default:
            begin
                mag = $urandom_range(0, 32'h0004_0000);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [63:0] random_payload();
        case ($urandom_range(7))
            0: return '1;
            1: return 64'd1 << $urandom_range(63);
            2: return 64'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random descriptor, biased so that big-endian signals mostly use the
    // legal byte counts and sit inside the frame.
    function automatic req_item_t random_write(logic [3:0] idx, logic [28:0] id,
                                               bit force_on);
        logic       be;
        logic [5:0] pos;
        logic [6:0] blen;

        be = $urandom_range(1);
        case ($urandom_range(5))
            0: blen = 7'd8;
            1: blen = 7'd16;
            2: blen = 7'd32;
            3: blen = 7'($urandom_range(64));
            4: blen = 7'($urandom);
            default: blen = 7'($urandom_range(1, 15));
        endcase
        if (be && $urandom_range(3) != 0)
            pos = 6'($urandom_range(7));
        else
            pos = 6'($urandom);
        return make_write(idx, force_on || ($urandom_range(9) != 0), id, be, pos, blen,
                          $urandom_range(1), pick_q16(), pick_q16());
    endfunction

    function automatic req_item_t random_frame(logic [28:0] id);
        logic [3:0] len;

        len = ($urandom_range(9) < 7) ? 4'd8 : 4'($urandom_range(15));
        return make_frame(id, len, random_payload());
    endfunction

    // Offers one item and holds it until the block takes it. The valid line
    // is left high on return, so the next call either keeps it high or drops
    // it for an idle cycle; either way it is assigned once per edge.
    task automatic send_item(input req_item_t it);
        while (take_break())
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        scoreboard.note_input(it);
        items_sent++;
    endtask

    // Directed part: a table that covers the decoding corners on one shared
    // identifier, two other identifiers, frames that hit them, and one that misses.
    task automatic run_directed();
        logic [28:0] shared_id;

        shared_id = 29'h1555_5555;
        // Big-endian with a bit length of zero reads a single byte.
        send_item(make_write(4'd0, 1'b1, shared_id, 1'b1, 6'd0, 7'd0, 1'b1,
                             Q16_ONE, 32'h0));
        // Two big-endian bytes at the end of the frame, sign-extended.
        send_item(make_write(4'd1, 1'b1, shared_id, 1'b1, 6'd6, 7'd16, 1'b1,
                             Q16_NEG, Q16_MAX));
        // Four big-endian bytes with the most extreme gain and offset.
        send_item(make_write(4'd2, 1'b1, shared_id, 1'b1, 6'd4, 7'd32, 1'b0,
                             Q16_MAX, Q16_MIN));
        // Three bytes is not a legal big-endian width and decodes to zero.
        send_item(make_write(4'd3, 1'b1, shared_id, 1'b1, 6'd0, 7'd24, 1'b0,
                             32'h1, 32'h5));
        // A big-endian signal that starts beyond the frame.
        send_item(make_write(4'd4, 1'b1, shared_id, 1'b1, 6'd63, 7'd8, 1'b0,
                             32'h1, 32'h7));
        // Whole 64-bit little-endian word, pushed into positive saturation.
        send_item(make_write(4'd5, 1'b1, shared_id, 1'b0, 6'd0, 7'd64, 1'b1,
                             Q16_MAX, Q16_MAX));
        // Top bit only, with an out-of-range length and the most negative gain.
        send_item(make_write(4'd6, 1'b1, shared_id, 1'b0, 6'd63, 7'd127, 1'b1,
                             Q16_MIN, 32'h0));
        // Zero-length little-endian field leaves only the offset.
        send_item(make_write(4'd7, 1'b1, shared_id, 1'b0, 6'd12, 7'd0, 1'b0,
                             32'h1, Q16_NEG));
        // Disabled slot carrying the same identifier must stay silent.
        send_item(make_write(4'd8, 1'b0, shared_id, 1'b0, 6'd0, 7'd8, 1'b0,
                             Q16_ONE, 32'h0));
        send_item(make_write(4'd15, 1'b1, shared_id, 1'b0, 6'd5, 7'd11, 1'b1,
                             Q16_ONE, 32'h0));
        // 63-bit signed field at the top identifier, driven into negative
        // saturation.
        send_item(make_write(4'd9, 1'b1, 29'h1FFF_FFFF, 1'b0, 6'd0, 7'd63, 1'b1,
                             Q16_MAX, Q16_MIN));
        send_item(make_write(4'd10, 1'b1, 29'h0, 1'b1, 6'd7, 7'd8, 1'b0,
                             Q16_ONE, 32'h0));

        // Oversized frame length counts as eight bytes.
        send_item(make_frame(shared_id, 4'd15, '1));
        send_item(make_frame(shared_id, 4'd8, 64'h7FFF_FFFF_FFFF_FFFF));
        // Short frames: the missing bytes read as zero.
        send_item(make_frame(shared_id, 4'd3, 64'h0123_4567_89AB_CDEF));
        send_item(make_frame(shared_id, 4'd0, 64'hDEAD_BEEF_F00D_CAFE));
        send_item(make_frame(29'h1FFF_FFFF, 4'd8, 64'h4000_0000_0000_0000));
        send_item(make_frame(29'h0, 4'd8, '1));
        // Byte seven lies outside a seven-byte frame.
        send_item(make_frame(29'h0, 4'd7, '1));
        // Identifier that no slot carries.
        send_item(make_frame(29'h0AAA_AAAA, 4'd8, {$urandom, $urandom}));
    endtask

    // Random part: each round picks a handful of identifiers, rewrites a few
    // slots (now and then all sixteen on one identifier, for the longest
    // burst of results), then sends frames mostly on those identifiers with
    // some stray identifiers as noise.
    task automatic run_random(input int count);
        logic [28:0] ids[4];
        logic [28:0] id;
        int          done;
        int          n;

        done = 0;
        while (done < count)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(7))
                    0: ids[k] = 29'h0;
                    1: ids[k] = 29'h1FFF_FFFF;
                    default: ids[k] = 29'($urandom);
                endcase
            end

            if ($urandom_range(7) == 0)
            begin
                for (int k = 0; k < TABLE_DEPTH_DEF; k++)
                begin
                    send_item(random_write(4'(k), ids[0], 1'b1));
                    done++;
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    id = ($urandom_range(9) != 0) ? ids[$urandom_range(3)] : 29'($urandom);
                    send_item(random_write(4'($urandom), id, 1'b0));
                    done++;
                end
            end

            n = $urandom_range(2, 8);
            for (int k = 0; k < n; k++)
            begin
                id = ($urandom_range(99) < 85) ? ids[$urandom_range(3)] : 29'($urandom);
                send_item(random_frame(id));
                done++;
            end

            steady = (done >= 120 && done < 200);
        end
        steady = 1'b0;
    endtask

    // Result side: checks every accepted result and stalls at random.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_if.valid && rsp_if.ready)
                    scoreboard.check_result(rsp_if.payload);
                rsp_if.ready <= !take_break();
            end
        end
    end

    // Watchdog: the run is declared hung once the quiet run reaches STALL_LIMIT.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("can_signal_table_decoder regression: fail");
        $finish;
    end

    // Main sequence: reset, directed items, random items, drain, verdict.
    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(280);
        req_if.valid <= 1'b0;

        while (scoreboard.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived",
                   scoreboard.expected_results.size());
            scoreboard.errors++;
        end

        $display("Sent %0d items: %0d descriptor writes and %0d frames.",
                 items_sent, scoreboard.writes, scoreboard.frames);
        $display("Checked %0d results, %0d of them saturated; busiest frame gave %0d.",
                 scoreboard.results, scoreboard.saturations, scoreboard.busiest);
        if (scoreboard.errors == 0)
            $display("can_signal_table_decoder regression: pass");
        else
            $display("can_signal_table_decoder regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
